@@ hw/rtl/ctn_pkg.sv @@
// Package for the capture tachometer needle block: field widths, register
// indexes, reset values and the sequencer state type.
// No dependencies; every other file imports it.
package ctn_pkg;

    localparam int CAP_W      = 16;   // capture word and period width
    localparam int TICK_W     = 24;   // tick_rate register
    localparam int PPR_W      = 8;    // pulses_per_rev register
    localparam int THR_W      = 16;   // change_threshold register
    localparam int SW_W       = 12;   // sector_width register
    localparam int SPEED_W    = 16;   // speed in RPM
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Shared divider: left-aligned dividend register and remainder register.
    localparam int DVD_W = 30;        // widest dividend: freq * 60
    localparam int REM_W = 24;        // widest divisor: the period, zero-extended
    localparam int CNT_W = 5;         // holds up to DVD_W steps

    localparam int SECTOR_COUNT_DEF = 12;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_WIDTH     = 4'd3;

    localparam logic [TICK_W-1:0] TICK_RATE_RST        = 24'd1000000;
    localparam logic [PPR_W-1:0]  PULSES_PER_REV_RST   = 8'd24;
    localparam logic [THR_W-1:0]  CHANGE_THRESHOLD_RST = 16'd7;
    localparam logic [SW_W-1:0]   SECTOR_WIDTH_RST     = 12'd15;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hffff;
    localparam logic [CAP_W-1:0]   WRAP_MAX  = 16'hffff;

    typedef enum logic [3:0] {
        ST_IDLE,      // waiting for a capture word
        ST_FREQ,      // tick_rate / period
        ST_MUL,       // freq * 60 loaded as the next dividend
        ST_RPM,       // (freq * 60) / pulses_per_rev
        ST_SAT,       // saturate to 16 bits
        ST_CHECK,     // compare against the shown speed
        ST_NEW,       // new speed / sector_width
        ST_LOAD_OLD,  // keep the new sector, load the shown speed
        ST_OLD,       // shown speed / sector_width
        ST_EMIT       // wait for the output register, then update
    } ctn_state_t;

endpackage

@@ hw/rtl/capture_tachometer_needle.sv @@
// Capture tachometer needle top level: pairs capture words, computes speed
// and needle sectors with one shared restoring divider. Depends on ctn_pkg.
//
//   Channel  Direction  Handshake              Word
//   s_       in         s_valid / s_ready      s_capture_value
//   m_       out        m_valid / m_ready      m_erase_sector, m_draw_sector,
//                                              m_speed_rpm
//   cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The first word of a pair is stored in the first-capture register. For the
// second word, no result is produced when the speed change stays within the
// threshold; a zero period skips the two speed divisions. The single
// divider retires one quotient bit per cycle: 24 steps for the frequency,
// 30 for the RPM and 16 for each sector.
// Reset is synchronous and active low; it restores the register defaults
// and clears the pairing state and the shown speed. A stalled result waits
// in the output register; the divider finishes its next item and then holds
// in its final state until that register is free.
module capture_tachometer_needle
    import ctn_pkg::*;
#(
    parameter int SECTOR_COUNT = SECTOR_COUNT_DEF,
    parameter int SECT_W       = $clog2(SECTOR_COUNT + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CAP_W-1:0]      s_capture_value,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SECT_W-1:0]     m_erase_sector,
    output logic [SECT_W-1:0]     m_draw_sector,
    output logic [SPEED_W-1:0]    m_speed_rpm,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Maps a sector quotient onto the dial, folding everything past the
    // last sector into the beyond-the-dial code.
    function automatic logic [SECT_W-1:0] clamp_sector(input logic [SPEED_W-1:0] quo);
        logic [SECT_W-1:0] res;
        if (quo >= SPEED_W'(SECTOR_COUNT)) begin
            res = SECT_W'(SECTOR_COUNT);
        end else begin
            res = quo[SECT_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [TICK_W-1:0] tick_rate_reg;
    logic [PPR_W-1:0]  pulses_per_rev_reg;
    logic [THR_W-1:0]  change_threshold_reg;
    logic [SW_W-1:0]   sector_width_reg;

    // Block state.
    ctn_state_t        state_reg, state_next;
    logic              awaiting_reg, awaiting_next;
    logic [CAP_W-1:0]  first_capture_reg, first_capture_next;
    logic [SPEED_W-1:0] shown_speed_reg, shown_speed_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [SECT_W-1:0] new_sector_reg, new_sector_next;

    // Shared divider.
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [REM_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [SECT_W-1:0] m_erase_reg, m_erase_next;
    logic [SECT_W-1:0] m_draw_reg, m_draw_next;
    logic [SPEED_W-1:0] m_speed_reg, m_speed_next;

    logic              in_fire;
    logic              out_free;
    logic              emit_fire;
    logic              div_last;
    logic [REM_W+1:0]  trial;
    logic              take;
    logic [REM_W-1:0]  step_rem;
    logic [DVD_W-1:0]  step_quo;
    logic [CAP_W-1:0]  period;
    logic [DVD_W-1:0]  freq_ext;
    logic [DVD_W-1:0]  rpm_dividend;
    logic [SPEED_W-1:0] speed_diff;
    logic              speed_changed;
    logic [PPR_W-1:0]  ppr_eff;
    logic [SW_W-1:0]   sw_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_rate_reg        <= TICK_RATE_RST;
            pulses_per_rev_reg   <= PULSES_PER_REV_RST;
            change_threshold_reg <= CHANGE_THRESHOLD_RST;
            sector_width_reg     <= SECTOR_WIDTH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TICK_RATE:        tick_rate_reg        <= cfg_data[TICK_W-1:0];
                REG_PULSES_PER_REV:   pulses_per_rev_reg   <= cfg_data[PPR_W-1:0];
                REG_CHANGE_THRESHOLD: change_threshold_reg <= cfg_data[THR_W-1:0];
                REG_SECTOR_WIDTH:     sector_width_reg     <= cfg_data[SW_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero divisors behave as one.
    assign ppr_eff = (pulses_per_rev_reg == '0) ? PPR_W'(1) : pulses_per_rev_reg;
    assign sw_eff  = (sector_width_reg == '0) ? SW_W'(1) : sector_width_reg;

    // Period from the first capture to the second; a second capture at or below the first one wraps.
    assign period = (s_capture_value > first_capture_reg)
                  ? s_capture_value - first_capture_reg
                  : (WRAP_MAX - first_capture_reg) + s_capture_value;

    // One restoring step: shift the next dividend bit into the remainder
    // and subtract the divisor when it fits.
    assign trial    = {1'b0, rem_reg, quo_reg[DVD_W-1]} - {2'b00, dvs_reg};
    assign take     = ~trial[REM_W+1];
    assign step_rem = take ? trial[REM_W-1:0] : {rem_reg[REM_W-2:0], quo_reg[DVD_W-1]};
    assign step_quo = {quo_reg[DVD_W-2:0], take};
    assign div_last = (cnt_reg == CNT_W'(1));

    // freq * 60 as (freq << 6) - (freq << 2); freq is at most 24 bits.
    assign freq_ext     = {{(DVD_W-TICK_W){1'b0}}, quo_reg[TICK_W-1:0]};
    assign rpm_dividend = (freq_ext << 6) - (freq_ext << 2);

    assign speed_diff    = (speed_reg > shown_speed_reg) ? speed_reg - shown_speed_reg
                                                          : shown_speed_reg - speed_reg;
    assign speed_changed = (speed_diff > change_threshold_reg);

    assign out_free  = ~m_valid_reg | m_ready;
    assign in_fire   = s_valid & s_ready;
    assign emit_fire = (state_reg == ST_EMIT) & out_free;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && awaiting_reg) begin
                    state_next = (period == '0) ? ST_CHECK : ST_FREQ;
                end
            end
            ST_FREQ:     if (div_last) state_next = ST_MUL;
            ST_MUL:      state_next = ST_RPM;
            ST_RPM:      if (div_last) state_next = ST_SAT;
            ST_SAT:      state_next = ST_CHECK;
            ST_CHECK:    state_next = speed_changed ? ST_NEW : ST_IDLE;
            ST_NEW:      if (div_last) state_next = ST_LOAD_OLD;
            ST_LOAD_OLD: state_next = ST_OLD;
            ST_OLD:      if (div_last) state_next = ST_EMIT;
            ST_EMIT:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        s_ready            = (state_reg == ST_IDLE);
        awaiting_next      = awaiting_reg;
        first_capture_next = first_capture_reg;
        shown_speed_next   = shown_speed_reg;
        speed_next         = speed_reg;
        new_sector_next    = new_sector_reg;
        quo_next           = quo_reg;
        rem_next           = rem_reg;
        dvs_next           = dvs_reg;
        cnt_next           = cnt_reg;
        m_valid_next       = m_valid_reg & ~m_ready;
        m_erase_next       = m_erase_reg;
        m_draw_next        = m_draw_reg;
        m_speed_next       = m_speed_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!awaiting_reg) begin
                        first_capture_next = s_capture_value;
                        awaiting_next      = 1'b1;
                    end else begin
                        awaiting_next = 1'b0;
                        speed_next    = SPEED_MAX;
                        quo_next      = {tick_rate_reg, {(DVD_W-TICK_W){1'b0}}};
                        rem_next      = '0;
                        dvs_next      = {{(REM_W-CAP_W){1'b0}}, period};
                        cnt_next      = CNT_W'(TICK_W);
                    end
                end
            end
            ST_FREQ, ST_RPM, ST_NEW, ST_OLD: begin
                quo_next = step_quo;
                rem_next = step_rem;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_MUL: begin
                quo_next = rpm_dividend;
                rem_next = '0;
                dvs_next = {{(REM_W-PPR_W){1'b0}}, ppr_eff};
                cnt_next = CNT_W'(DVD_W);
            end
            ST_SAT: begin
                speed_next = (quo_reg[DVD_W-1:SPEED_W] != '0) ? SPEED_MAX
                                                               : quo_reg[SPEED_W-1:0];
            end
            ST_CHECK: begin
                quo_next = {speed_reg, {(DVD_W-SPEED_W){1'b0}}};
                rem_next = '0;
                dvs_next = {{(REM_W-SW_W){1'b0}}, sw_eff};
                cnt_next = CNT_W'(SPEED_W);
            end
            ST_LOAD_OLD: begin
                new_sector_next = clamp_sector(quo_reg[SPEED_W-1:0]);
                quo_next        = {shown_speed_reg, {(DVD_W-SPEED_W){1'b0}}};
                rem_next        = '0;
                cnt_next        = CNT_W'(SPEED_W);
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    m_valid_next     = 1'b1;
                    m_erase_next     = clamp_sector(quo_reg[SPEED_W-1:0]);
                    m_draw_next      = new_sector_reg;
                    m_speed_next     = speed_reg;
                    shown_speed_next = speed_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            awaiting_reg      <= 1'b0;
            first_capture_reg <= '0;
            shown_speed_reg   <= '0;
            m_valid_reg       <= 1'b0;
            cnt_reg           <= '0;
        end else begin
            state_reg         <= state_next;
            awaiting_reg      <= awaiting_next;
            first_capture_reg <= first_capture_next;
            shown_speed_reg   <= shown_speed_next;
            m_valid_reg       <= m_valid_next;
            cnt_reg           <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        speed_reg      <= speed_next;
        new_sector_reg <= new_sector_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        dvs_reg        <= dvs_next;
        m_erase_reg    <= m_erase_next;
        m_draw_reg     <= m_draw_next;
        m_speed_reg    <= m_speed_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_erase_sector = m_erase_reg;
    assign m_draw_sector  = m_draw_reg;
    assign m_speed_rpm    = m_speed_reg;

endmodule

@@ hw/rtl/ctn_checker.sv @@
// Port-level checks for the capture tachometer needle block, bound to the
// top level. Depends on ctn_pkg and capture_tachometer_needle.
module ctn_checker
    import ctn_pkg::*;
#(
    parameter int SECTOR_COUNT = SECTOR_COUNT_DEF,
    parameter int SECT_W       = $clog2(SECTOR_COUNT + 1)
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [SECT_W-1:0]  m_erase_sector,
    input logic [SECT_W-1:0]  m_draw_sector,
    input logic [SPEED_W-1:0] m_speed_rpm
);

    // A stalled result keeps m_valid high and its speed word stable.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_speed_rpm))
        else $error("stalled result word changed");

    // Sectors never pass the beyond-the-dial code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_draw_sector <= SECT_W'(SECTOR_COUNT))
                 && (m_erase_sector <= SECT_W'(SECTOR_COUNT)))
        else $error("sector out of range");

    // A new result only appears after the divider was busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a computation");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word survived reset");

endmodule

bind capture_tachometer_needle ctn_checker #(
    .SECTOR_COUNT (SECTOR_COUNT),
    .SECT_W       (SECT_W)
) u_ctn_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_erase_sector (m_erase_sector),
    .m_draw_sector  (m_draw_sector),
    .m_speed_rpm    (m_speed_rpm)
);
